>>> rtl/core/rsbp_pkg.sv
// Shared types, widths and helpers for the row shelf block placer.
// Used by the channel interfaces, controller, datapath and top level.
`default_nettype none

package rsbp_pkg;

  localparam int unsigned SEGS_PER_ROW_DEF = 64;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned SIZE_W  = 24;
  localparam int unsigned ROW_W   = 8;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [SIZE_W-1:0]  size_t;
  typedef logic [ROW_W-1:0]   row_t;

  localparam coord_t COORD_MAX  = '1;
  localparam row_t   ROW_MAX    = '1;
  localparam coord_t LIMIT_RST  = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_SCAN,
    ST_FINISH
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // latch the incoming word
    logic prep;      // apply clear, form x and right edge
    logic rd_issue;  // read next previous-row segment
    logic cmp;       // compare the segment read last cycle
    logic finish;    // store segment, update state, load result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic rd_more;   // previous-row segments left to read
    logic stop_hit;  // segment read last cycle starts past the right edge
    logic out_busy;  // result register still held by the receiver
  } status_t;

  typedef struct packed {
    coord_t x0;
    coord_t x1;
    coord_t top;
  } seg_t;

  function automatic coord_t sat_add(input coord_t a, input coord_t b);
    logic [COORD_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COORD_W] ? COORD_MAX : s[COORD_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/rsbp_if.sv
// Valid/ready channel interfaces: block words in, placement words out.
// Depends on rsbp_pkg for field widths.
`default_nettype none

interface rsbp_blk_if;
  logic                  valid;
  logic                  ready;
  rsbp_pkg::size_t       block_width;
  rsbp_pkg::size_t       block_height;
  logic                  first_block;

  modport source (output valid, block_width, block_height, first_block, input ready);
  modport sink   (input valid, block_width, block_height, first_block, output ready);
endinterface

interface rsbp_plc_if;
  logic                  valid;
  logic                  ready;
  rsbp_pkg::coord_t      pos_x;
  rsbp_pkg::coord_t      pos_y;
  rsbp_pkg::row_t        row_index;
  rsbp_pkg::coord_t      right_extent;
  rsbp_pkg::coord_t      top_extent;
  logic                  row_full;

  modport source (output valid, pos_x, pos_y, row_index, right_extent, top_extent, row_full,
                  input ready);
  modport sink   (input valid, pos_x, pos_y, row_index, right_extent, top_extent, row_full,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/core/rsbp_ctrl.sv
// Sequencer for the placer: accept, prepare, scan previous row, finish.
// Depends on rsbp_pkg; drives the datapath through cmd_t, reads status_t.
`default_nettype none

module rsbp_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire rsbp_pkg::status_t sts,
  output rsbp_pkg::cmd_t         cmd
);

  rsbp_pkg::state_t state, state_next;
  logic             rvalid, rvalid_next;  // read data of last cycle is live
  logic             hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= rsbp_pkg::ST_IDLE;
      rvalid <= 1'b0;
    end else begin
      state  <= state_next;
      rvalid <= rvalid_next;
    end
  end

  always_comb begin
    state_next  = state;
    rvalid_next = 1'b0;
    in_ready    = 1'b0;
    cmd         = '0;
    hit         = 1'b0;
    case (state)
      rsbp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = rsbp_pkg::ST_PREP;
        end
      end
      rsbp_pkg::ST_PREP: begin
        cmd.prep   = 1'b1;
        state_next = rsbp_pkg::ST_SCAN;
      end
      rsbp_pkg::ST_SCAN: begin
        // reads run one ahead of the compares; stop early on a segment
        // that starts right of the block
        hit          = rvalid && sts.stop_hit;
        cmd.cmp      = rvalid;
        cmd.rd_issue = sts.rd_more && !hit;
        rvalid_next  = cmd.rd_issue;
        if (hit || !sts.rd_more) begin
          state_next = rsbp_pkg::ST_FINISH;
        end
      end
      rsbp_pkg::ST_FINISH: begin
        if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          state_next = rsbp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rsbp_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/core/rsbp_dp.sv
// Placer datapath: position and bound registers, ping-pong segment store,
// skyline compare and the result register.
// Depends on rsbp_pkg; commanded by rsbp_ctrl.
`default_nettype none

module rsbp_dp #(
  parameter int unsigned SEGS_PER_ROW = rsbp_pkg::SEGS_PER_ROW_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_wr_en,
  input  wire rsbp_pkg::coord_t  cfg_wr_data,
  input  wire rsbp_pkg::size_t   in_width,
  input  wire rsbp_pkg::size_t   in_height,
  input  wire logic              in_first,
  input  wire rsbp_pkg::cmd_t    cmd,
  output rsbp_pkg::status_t      sts,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output rsbp_pkg::coord_t       out_pos_x,
  output rsbp_pkg::coord_t       out_pos_y,
  output rsbp_pkg::row_t         out_row_index,
  output rsbp_pkg::coord_t       out_right_extent,
  output rsbp_pkg::coord_t       out_top_extent,
  output logic                   out_row_full
);

  localparam int unsigned AW    = $clog2(SEGS_PER_ROW);
  localparam int unsigned CW    = $clog2(SEGS_PER_ROW + 1);
  localparam int unsigned MAW   = AW + 1;
  localparam int unsigned DEPTH = 2 * SEGS_PER_ROW;

  localparam logic [CW-1:0]  SEG_FULL  = CW'(SEGS_PER_ROW);
  localparam logic [MAW-1:0] BANK_BASE = MAW'(SEGS_PER_ROW);

  // state
  rsbp_pkg::coord_t row_limit;
  rsbp_pkg::coord_t next_x;
  rsbp_pkg::row_t   cur_row;
  logic [CW-1:0]    prev_count;
  logic [CW-1:0]    cur_count;
  rsbp_pkg::coord_t max_right;
  rsbp_pkg::coord_t max_top;
  logic             bank;          // bank holding the current row

  // per word working registers
  rsbp_pkg::size_t  w_r;
  rsbp_pkg::size_t  h_r;
  logic             first_r;
  rsbp_pkg::coord_t x_r;
  rsbp_pkg::coord_t end_r;
  rsbp_pkg::row_t   row_r;
  rsbp_pkg::coord_t y_r;
  logic [CW-1:0]    rd_idx;

  rsbp_pkg::seg_t   mem [DEPTH];
  rsbp_pkg::seg_t   rdata;

  rsbp_pkg::coord_t x_eff;
  logic [MAW-1:0]   rd_addr;
  logic [MAW-1:0]   wr_addr;
  logic             overlap;
  rsbp_pkg::coord_t top_new;
  rsbp_pkg::coord_t mr_new;
  rsbp_pkg::coord_t mt_new;
  logic             dropped;
  logic             wrap;
  logic [CW-1:0]    cur_count_new;
  rsbp_pkg::seg_t   wr_seg;

  always_comb begin
    x_eff   = first_r ? '0 : next_x;
    rd_addr = (bank ? '0 : BANK_BASE) + MAW'(rd_idx[AW-1:0]);
    wr_addr = (bank ? BANK_BASE : '0) + MAW'(cur_count[AW-1:0]);
    overlap = (rdata.x0 <= end_r) && (x_r <= rdata.x1);
    top_new = rsbp_pkg::sat_add(y_r, rsbp_pkg::coord_t'(h_r));
    mr_new  = (end_r > max_right) ? end_r : max_right;
    mt_new  = (top_new > max_top) ? top_new : max_top;
    dropped = (cur_count >= SEG_FULL);
    wrap    = (end_r >= row_limit);
    cur_count_new = dropped ? cur_count : CW'(cur_count + 1'b1);
    wr_seg.x0  = x_r;
    wr_seg.x1  = end_r;
    wr_seg.top = top_new;

    sts.rd_more  = (row_r != '0) && (rd_idx < prev_count);
    sts.stop_hit = (end_r < rdata.x0);
    sts.out_busy = out_valid && !out_ready;
  end

  // segment store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.finish && !dropped) begin
      mem[wr_addr] <= wr_seg;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      rdata <= mem[rd_addr];
    end
  end

  // working registers, no reset
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      w_r     <= in_width;
      h_r     <= in_height;
      first_r <= in_first;
    end
    if (cmd.prep) begin
      x_r    <= x_eff;
      end_r  <= rsbp_pkg::sat_add(x_eff, rsbp_pkg::coord_t'(w_r));
      row_r  <= first_r ? '0 : cur_row;
      y_r    <= '0;
      rd_idx <= '0;
    end
    if (cmd.rd_issue) begin
      rd_idx <= CW'(rd_idx + 1'b1);
    end
    if (cmd.cmp && overlap && (rdata.top > y_r)) begin
      y_r <= rdata.top;
    end
    if (cmd.finish) begin
      out_pos_x        <= x_r;
      out_pos_y        <= y_r;
      out_row_index    <= row_r;
      out_right_extent <= mr_new;
      out_top_extent   <= mt_new;
      out_row_full     <= dropped;
    end
  end

  // placement state
  always_ff @(posedge clk) begin
    if (rst) begin
      row_limit  <= rsbp_pkg::LIMIT_RST;
      next_x     <= '0;
      cur_row    <= '0;
      prev_count <= '0;
      cur_count  <= '0;
      max_right  <= '0;
      max_top    <= '0;
      bank       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        row_limit <= cfg_wr_data;
      end
      if (cmd.prep && first_r) begin
        cur_row    <= '0;
        prev_count <= '0;
        cur_count  <= '0;
        max_right  <= '0;
        max_top    <= '0;
      end
      if (cmd.finish) begin
        max_right <= mr_new;
        max_top   <= mt_new;
        if (wrap) begin
          // swap banks instead of copying the row
          bank       <= !bank;
          prev_count <= cur_count_new;
          cur_count  <= '0;
          next_x     <= '0;
          if (cur_row != rsbp_pkg::ROW_MAX) begin
            cur_row <= rsbp_pkg::row_t'(cur_row + 1'b1);
          end
        end else begin
          cur_count <= cur_count_new;
          next_x    <= end_r;
        end
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/row_shelf_block_placer.sv
// Top level of the row shelf block placer: controller plus datapath.
// Depends on rsbp_pkg, rsbp_if, rsbp_ctrl and rsbp_dp.
//
// Usage: block words (width, height, first_block) arrive on the blocks
// channel in placement order; one placement word per block leaves on the
// places channel (x, y, row, running right/top bounds, row_full).
// The user must write row_limit through cfg_wr_en/cfg_wr_data only while
// the block is idle; the block itself does not enforce this. One block at
// a time: a word is accepted, prepared, scanned against the previous-row
// segments (none on row 0, at most SEGS_PER_ROW, fewer on an early stop) and
// finished before the next ready. The scan reads the segment store one entry
// a cycle through its single registered read port. The result is registered.
// A held result does not block acceptance of the next word; that word waits
// in its last step only until the result register is free.
// Reset (rst, synchronous) sets row_limit to all ones, clears position, row,
// segment counts and bounds; the segment store itself is not cleared.
// first_block on a word clears the same placement state before placing it.
`default_nettype none

module row_shelf_block_placer #(
  parameter int unsigned SEGS_PER_ROW = rsbp_pkg::SEGS_PER_ROW_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_wr_en,
  input  wire rsbp_pkg::coord_t  cfg_wr_data,
  rsbp_blk_if.sink               blocks,
  rsbp_plc_if.source             places
);

  rsbp_pkg::cmd_t    cmd;
  rsbp_pkg::status_t sts;

  rsbp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (blocks.valid),
    .in_ready (blocks.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rsbp_dp #(
    .SEGS_PER_ROW (SEGS_PER_ROW)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_width         (blocks.block_width),
    .in_height        (blocks.block_height),
    .in_first         (blocks.first_block),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (places.valid),
    .out_ready        (places.ready),
    .out_pos_x        (places.pos_x),
    .out_pos_y        (places.pos_y),
    .out_row_index    (places.row_index),
    .out_right_extent (places.right_extent),
    .out_top_extent   (places.top_extent),
    .out_row_full     (places.row_full)
  );

endmodule

`default_nettype wire

>>> rtl/core/rsbp_checker.sv
// Port-level checks for the placer, bound onto the top level.
// Depends on rsbp_pkg for field types.
`default_nettype none

module rsbp_checker (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              blk_valid,
  input  wire logic              blk_ready,
  input  wire logic              plc_valid,
  input  wire logic              plc_ready,
  input  wire rsbp_pkg::coord_t  pos_x,
  input  wire rsbp_pkg::coord_t  pos_y,
  input  wire rsbp_pkg::row_t    row_index,
  input  wire rsbp_pkg::coord_t  right_extent,
  input  wire rsbp_pkg::coord_t  top_extent
);

  logic       blk_acc;
  logic       plc_acc;
  logic [1:0] pending;   // words accepted but not yet delivered

  assign blk_acc = blk_valid && blk_ready;
  assign plc_acc = plc_valid && plc_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= 2'(pending + {1'b0, blk_acc} - {1'b0, plc_acc});
    end
  end

  a_held: assert property (@(posedge clk) disable iff (rst)
    plc_valid && !plc_ready |=> plc_valid && $stable(pos_x) && $stable(pos_y))
    else $error("placement word changed while stalled");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    plc_acc |-> pending != 2'd0)
    else $error("placement word without an accepted block");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    blk_acc |=> !blk_ready)
    else $error("block accepted while previous one in progress");

  a_row0_floor: assert property (@(posedge clk) disable iff (rst)
    plc_valid && row_index == '0 |-> pos_y == '0)
    else $error("block on first row not on the floor");

  a_bounds: assert property (@(posedge clk) disable iff (rst)
    plc_valid |-> top_extent >= pos_y && right_extent >= pos_x)
    else $error("running bounds below placed position");

endmodule

bind row_shelf_block_placer rsbp_checker u_rsbp_checker (
  .clk          (clk),
  .rst          (rst),
  .blk_valid    (blocks.valid),
  .blk_ready    (blocks.ready),
  .plc_valid    (places.valid),
  .plc_ready    (places.ready),
  .pos_x        (places.pos_x),
  .pos_y        (places.pos_y),
  .row_index    (places.row_index),
  .right_extent (places.right_extent),
  .top_extent   (places.top_extent)
);

`default_nettype wire
